/* rtl/pdde_pkg.sv */
// Shared types and constants for the packet delay/drop emulator.
package pdde_pkg;
	localparam int QueueDepth = 16;
	localparam int TagBits    = 16;
	localparam int TimeBits   = 32;
	localparam int LevelBits  = $clog2(QueueDepth + 1);

	localparam logic [2:0] KIND_QUEUED    = 3'd0;
	localparam logic [2:0] KIND_DROPPED   = 3'd1;
	localparam logic [2:0] KIND_REFUSED   = 3'd2;
	localparam logic [2:0] KIND_DELIVERED = 3'd3;
	localparam logic [2:0] KIND_NONE      = 3'd4;

	localparam logic [1:0] REG_BASE  = 2'd0;
	localparam logic [1:0] REG_SPAN  = 2'd1;
	localparam logic [1:0] REG_DROP  = 2'd2;
	localparam logic [1:0] REG_SEED  = 2'd3;

	typedef struct packed {
		logic                req_type;
		logic [TagBits-1:0]  packet_tag;
		logic [15:0]         tick_amount;
	} req_t;

	typedef struct packed {
		logic [2:0]           result_kind;
		logic [15:0]          out_tag;
		logic [15:0]          drops_so_far;
		logic [LevelBits-1:0] queue_level;
		logic                 last;
	} rsp_t;

	// Chain control broadcast to every cell.
	typedef struct packed {
		logic                insert;
		logic                pop;
		logic [TimeBits-1:0] due;
		logic [TagBits-1:0]  tag;
	} chain_ctl_t;

	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction
endpackage

/* rtl/pdde_if.sv */
// Valid/ready channel interface for requests and results.
interface pdde_req_if;
	import pdde_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface pdde_rsp_if;
	import pdde_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pdde_cell.sv */
// One queue cell: holds a slot and shifts with its neighbors on insert/pop.
module pdde_cell import pdde_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  chain_ctl_t          ctl,
	input  logic                left_valid,
	input  logic                left_later,
	input  logic [TimeBits-1:0] left_due,
	input  logic [TagBits-1:0]  left_tag,
	input  logic                right_valid,
	input  logic [TimeBits-1:0] right_due,
	input  logic [TagBits-1:0]  right_tag,
	output logic                valid_q,
	output logic                later,
	output logic [TimeBits-1:0] due_q,
	output logic [TagBits-1:0]  tag_q
);
	assign later = valid_q && (due_q > ctl.due);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= right_valid;
		end else if (ctl.insert) begin
			valid_q <= valid_q || left_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			due_q <= right_due;
			tag_q <= right_tag;
		end else if (ctl.insert) begin
			if ((later || !valid_q) && left_later) begin
				due_q <= left_due;
				tag_q <= left_tag;
			end else if (later || (!valid_q && left_valid)) begin
				due_q <= ctl.due;
				tag_q <= ctl.tag;
			end
		end
	end
endmodule

/* rtl/pdde_chain.sv */
// Sorted row of queue cells with head view.
module pdde_chain import pdde_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  chain_ctl_t          ctl,
	output logic                head_valid,
	output logic [TimeBits-1:0] head_due,
	output logic [TagBits-1:0]  head_tag,
	output logic                next_valid,
	output logic [TimeBits-1:0] next_due
);
	logic [QueueDepth-1:0]               v;
	logic [QueueDepth-1:0]               lt;
	logic [QueueDepth-1:0][TimeBits-1:0] d;
	logic [QueueDepth-1:0][TagBits-1:0]  t;

	for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
		logic                lv, ll, rv;
		logic [TimeBits-1:0] ld, rd;
		logic [TagBits-1:0]  ltg, rtg;
		if (i == 0) begin : g_first
			assign lv = 1'b1;
			assign ll = 1'b0;
			assign ld = '0;
			assign ltg = '0;
		end else begin : g_mid
			assign lv = v[i-1];
			assign ll = lt[i-1];
			assign ld = d[i-1];
			assign ltg = t[i-1];
		end
		if (i == QueueDepth - 1) begin : g_last
			assign rv = 1'b0;
			assign rd = '0;
			assign rtg = '0;
		end else begin : g_inner
			assign rv = v[i+1];
			assign rd = d[i+1];
			assign rtg = t[i+1];
		end
		pdde_cell u_cell (
			.clk, .arst_n, .ctl,
			.left_valid(lv), .left_later(ll), .left_due(ld), .left_tag(ltg),
			.right_valid(rv), .right_due(rd), .right_tag(rtg),
			.valid_q(v[i]), .later(lt[i]), .due_q(d[i]), .tag_q(t[i])
		);
	end

	assign head_valid = v[0];
	assign head_due   = d[0];
	assign head_tag   = t[0];
	assign next_valid = v[1];
	assign next_due   = d[1];

`ifndef SYNTH
	for (genvar i = 1; i < QueueDepth; i++) begin : g_chk
		a_packed: assert property (@(posedge clk) disable iff (!arst_n)
			v[i] |-> v[i-1]) else $error("queue hole");
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			v[i] |-> d[i-1] <= d[i]) else $error("queue order");
	end
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.insert && ctl.pop)) else $error("insert and pop together");
`endif
endmodule

/* rtl/packet_delay_drop_emulator.sv */
// Top level: packet delay, jitter and drop emulator.
// A send is handled in two states: S_IDLE makes the drop draw and the jitter
// multiply, S_SEND computes the due time and inserts the tag into a sorted
// chain of cells, all shifting in one step, or refuses it if the chain is
// full; a dropped send gives its result from S_IDLE. A tick advances time,
// then releases one due packet per cycle while the output moves (up to 16)
// from the chain head, or gives one none-ready result. Each result waits in
// an output register; the next request is taken once it is moved on. Seed
// writes (zero loads as 1) reload the generator unless a send is taken too.
module packet_delay_drop_emulator import pdde_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pdde_req_if.sink    req,
	pdde_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);
	typedef enum logic [1:0] {S_IDLE, S_SEND, S_REL} state_t;

	state_t              state_q;
	logic [15:0]         base_q, span_q;
	logic [16:0]         thr_q;
	logic [31:0]         rnd_q;
	logic [TimeBits-1:0] now_q;
	logic [15:0]         drops_q;
	logic [LevelBits-1:0] fill_q;
	logic [4:0]          rel_cnt_q;
	logic [TagBits-1:0]  tag_q;
	logic [48:0]         prod_s1;
	logic                out_valid_q;
	rsp_t                out_q;
	logic                head_valid;
	logic [TimeBits-1:0] head_due;
	logic [TagBits-1:0]  head_tag;
	logic                next_valid;
	logic [TimeBits-1:0] next_due;
	chain_ctl_t          ctl;

	logic [31:0]         r1, r2;
	logic [17:0]         up;
	logic [16:0]         lat;
	logic [TimeBits:0]   due_sum, now_sum;
	logic                can_out, due_now, dropped;
	logic                next_due_now, last_pop, out_load;

	assign can_out = !out_valid_q || rsp.ready;
	assign r1 = xorshift(rnd_q);
	assign r2 = xorshift(r1);
	assign dropped = {1'b0, r1[31:16]} < thr_q;
	assign up = {2'b0, base_q} + {1'b0, prod_s1[48:32]};
	assign lat = (up > {2'b0, span_q}) ? 17'(up - {2'b0, span_q}) : 17'd0;
	assign due_sum = {1'b0, now_q} + (TimeBits+1)'(lat);
	assign now_sum = {1'b0, now_q} + (TimeBits+1)'(req.data.tick_amount);
	assign due_now = head_valid && (head_due <= now_q);
	assign next_due_now = next_valid && (next_due <= now_q);
	assign last_pop = (rel_cnt_q == 5'd15) || !next_due_now;
	assign out_load = ((state_q == S_IDLE) && req.valid && req.ready &&
			!req.data.req_type && dropped) ||
		((state_q == S_SEND) && can_out) ||
		((state_q == S_REL) && can_out && (ctl.pop || rel_cnt_q == '0));

	assign req.ready = (state_q == S_IDLE) && can_out;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	always_comb begin
		ctl.insert = (state_q == S_SEND) && can_out && (fill_q < LevelBits'(QueueDepth));
		ctl.pop    = (state_q == S_REL) && can_out && due_now;
		ctl.due    = due_sum[TimeBits] ? '1 : due_sum[TimeBits-1:0];
		ctl.tag    = tag_q;
	end

	pdde_chain u_chain (
		.clk, .arst_n, .ctl,
		.head_valid, .head_due, .head_tag,
		.next_valid, .next_due
	);

	always_ff @(posedge clk) begin
		prod_s1 <= 49'(r2) * 49'({span_q, 1'b1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			span_q      <= '0;
			thr_q       <= '0;
			rnd_q       <= 32'd1;
			now_q       <= '0;
			drops_q     <= '0;
			fill_q      <= '0;
			rel_cnt_q   <= '0;
			tag_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && !rsp.ready);
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE: base_q <= cfg_wdata[15:0];
					REG_SPAN: span_q <= cfg_wdata[15:0];
					REG_DROP: thr_q  <= cfg_wdata[16:0];
					REG_SEED: rnd_q  <= (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						if (!req.data.req_type) begin
							tag_q <= req.data.packet_tag;
							if (dropped) begin
								rnd_q <= r1;
								out_q <= '{KIND_DROPPED, req.data.packet_tag,
									(drops_q == 16'hFFFF) ? drops_q : drops_q + 16'd1,
									fill_q, 1'b1};
								if (drops_q != 16'hFFFF) drops_q <= drops_q + 16'd1;
							end else begin
								rnd_q <= r2;
								state_q <= S_SEND;
							end
						end else begin
							now_q <= now_sum[TimeBits] ? '1 : now_sum[TimeBits-1:0];
							rel_cnt_q <= '0;
							state_q <= S_REL;
						end
					end
				end
				S_SEND: begin
					if (can_out) begin
						state_q <= S_IDLE;
						if (ctl.insert) begin
							fill_q <= fill_q + 1'b1;
							out_q <= '{KIND_QUEUED, tag_q, drops_q, fill_q + 1'b1, 1'b1};
						end else begin
							out_q <= '{KIND_REFUSED, tag_q, drops_q, fill_q, 1'b1};
						end
					end
				end
				S_REL: begin
					if (can_out) begin
						if (ctl.pop) begin
							fill_q <= fill_q - 1'b1;
							rel_cnt_q <= rel_cnt_q + 5'd1;
							out_q <= '{KIND_DELIVERED, head_tag, drops_q, fill_q - 1'b1,
								last_pop};
							if (last_pop) state_q <= S_IDLE;
						end else begin
							if (rel_cnt_q == '0) out_q <= '{KIND_NONE, '0, drops_q, fill_q, 1'b1};
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LevelBits'(QueueDepth)) else $error("fill overflow");
	a_fill_head: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0) == head_valid) else $error("fill/head mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp.ready |=> out_valid_q && $stable(out_q))
		else $error("result lost");
`endif
endmodule
